/* rtl/sct_pkg.sv */
// Shared types and constants for the source character tokenizer.
// Used by the front scanner, the token queue, the output stage and the top level.
package sct_pkg;

    localparam int TOKENS_PER_ITEM = 3;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [4:0] K_LPAREN = 5'd0;
    localparam logic [4:0] K_RPAREN = 5'd1;
    localparam logic [4:0] K_LBRACE = 5'd2;
    localparam logic [4:0] K_RBRACE = 5'd3;
    localparam logic [4:0] K_SEMI   = 5'd4;
    localparam logic [4:0] K_PLUS   = 5'd5;
    localparam logic [4:0] K_MINUS  = 5'd6;
    localparam logic [4:0] K_STAR   = 5'd7;
    localparam logic [4:0] K_SLASH  = 5'd8;
    localparam logic [4:0] K_EQ     = 5'd9;
    localparam logic [4:0] K_EQEQ   = 5'd10;
    localparam logic [4:0] K_LESS   = 5'd11;
    localparam logic [4:0] K_SHL    = 5'd12;
    localparam logic [4:0] K_SHR    = 5'd13;
    localparam logic [4:0] K_AMP    = 5'd14;
    localparam logic [4:0] K_PIPE   = 5'd15;
    localparam logic [4:0] K_CARET  = 5'd16;
    localparam logic [4:0] K_NUMBER = 5'd17;
    localparam logic [4:0] K_IDENT  = 5'd18;
    localparam logic [4:0] K_KW0    = 5'd19;
    localparam logic [4:0] K_EOF    = 5'd25;

    localparam int NUM_KEYWORDS = 6;

    // Keyword text, first character in the lowest byte: let, if, else, while, print, input.
    localparam logic [39:0] KW_TEXT [NUM_KEYWORDS] = '{
        40'h00_0074_656C,
        40'h00_0000_6669,
        40'h00_6573_6C65,
        40'h65_6C69_6877,
        40'h74_6E69_7270,
        40'h74_7570_6E69
    };
    localparam logic [2:0] KW_LEN [NUM_KEYWORDS] = '{3'd3, 3'd2, 3'd4, 3'd5, 3'd5, 3'd5};

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [15:0] line;
    } tok_t;

    // One queue entry holds every token that a single input transaction produced.
    typedef struct packed {
        logic [1:0]       count;
        tok_t [2:0]       tok;
    } entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

/* rtl/sct_front.sv */
// Front scanner: accepts source bytes, keeps the scan state and builds the tokens of each byte.
// Depends on sct_pkg; feeds sct_queue.
module sct_front
    import sct_pkg::*;
#(
    parameter int POS_W     = 16,
    parameter int POS_CAP   = 65535,
    parameter int KW_CHARS  = 5
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_byte,
    input  logic       has_char,
    input  logic       end_of_source,
    input  q_status_t  q_stat,
    output logic       push,
    output entry_t     push_entry
);

    localparam int PF_W = 8 * KW_CHARS;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_NL     = 8'h0A;

    typedef enum logic [2:0] {M_IDLE, M_EQ, M_LT, M_GT, M_NUM, M_ID} mode_t;

    typedef struct packed {
        logic valid;
        tok_t tok;
    } flush_t;

    mode_t              mode_reg, mode_next;
    logic [POS_W-1:0]   start_reg, start_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [15:0]        line_reg, line_next;
    logic [PF_W-1:0]    prefix_reg, prefix_next;
    logic [15:0]        runlen_reg, runlen_next;

    tok_t [2:0]         toks;
    logic [1:0]         cnt;
    logic               consumed;
    logic               is_digit;
    logic               is_alpha;
    logic [4:0]         punct_kind;
    logic               is_punct;
    flush_t             fl;
    logic               accept;

    function automatic logic [4:0] ident_kind(logic [15:0] rl, logic [PF_W-1:0] pf);
        logic [4:0] kind;
        kind = K_IDENT;
        for (int k = 0; k < NUM_KEYWORDS; k++) begin
            if (rl == 16'(KW_LEN[k]) && pf == PF_W'(KW_TEXT[k])) begin
                kind = K_KW0 + 5'(k);
            end
        end
        return kind;
    endfunction

    function automatic flush_t flush_tok(mode_t m, logic [POS_W-1:0] st, logic [15:0] rl,
                                         logic [PF_W-1:0] pf, logic [15:0] ln);
        flush_t f;
        f.valid     = 1'b1;
        f.tok.start = 16'(st);
        f.tok.line  = ln;
        f.tok.len   = 16'd1;
        f.tok.kind  = K_EQ;
        unique case (m)
            M_EQ:  f.tok.kind = K_EQ;
            M_LT:  f.tok.kind = K_LESS;
            M_NUM:
            begin
                f.tok.kind = K_NUMBER;
                f.tok.len  = rl;
            end
            M_ID:
            begin
                f.tok.kind = ident_kind(rl, pf);
                f.tok.len  = rl;
            end
            default: f.valid = 1'b0;
        endcase
        return f;
    endfunction

    assign is_digit = (char_byte >= 8'h30) && (char_byte <= 8'h39);
    assign is_alpha = ((char_byte >= 8'h61) && (char_byte <= 8'h7A)) ||
                      ((char_byte >= 8'h41) && (char_byte <= 8'h5A));

    always_comb
    begin
        is_punct   = 1'b1;
        punct_kind = K_LPAREN;
        unique case (char_byte)
            CH_LPAREN: punct_kind = K_LPAREN;
            CH_RPAREN: punct_kind = K_RPAREN;
            CH_LBRACE: punct_kind = K_LBRACE;
            CH_RBRACE: punct_kind = K_RBRACE;
            CH_SEMI:   punct_kind = K_SEMI;
            CH_PLUS:   punct_kind = K_PLUS;
            CH_MINUS:  punct_kind = K_MINUS;
            CH_STAR:   punct_kind = K_STAR;
            CH_SLASH:  punct_kind = K_SLASH;
            CH_AMP:    punct_kind = K_AMP;
            CH_PIPE:   punct_kind = K_PIPE;
            CH_CARET:  punct_kind = K_CARET;
            default:   is_punct = 1'b0;
        endcase
    end

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        mode_next   = mode_reg;
        start_next  = start_reg;
        pos_next    = pos_reg;
        line_next   = line_reg;
        prefix_next = prefix_reg;
        runlen_next = runlen_reg;
        toks        = '0;
        cnt         = 2'd0;
        consumed    = 1'b0;
        fl          = '0;

        if (has_char) begin
            case (mode_reg)
                M_EQ, M_LT, M_GT:
                begin
                    if ((mode_reg == M_EQ && char_byte == CH_EQ) ||
                        (mode_reg == M_LT && char_byte == CH_LT) ||
                        (mode_reg == M_GT && char_byte == CH_GT)) begin
                        toks[cnt].kind  = (mode_reg == M_EQ) ? K_EQEQ :
                                          (mode_reg == M_LT) ? K_SHL : K_SHR;
                        toks[cnt].start = 16'(start_reg);
                        toks[cnt].len   = 16'd2;
                        toks[cnt].line  = line_next;
                        cnt       = cnt + 2'd1;
                        mode_next = M_IDLE;
                        consumed  = 1'b1;
                    end
                end
                M_NUM:
                begin
                    if (is_digit) begin
                        if (runlen_reg != 16'hFFFF) runlen_next = runlen_reg + 16'd1;
                        consumed = 1'b1;
                    end
                end
                M_ID:
                begin
                    if (is_digit || is_alpha) begin
                        for (int i = 0; i < KW_CHARS; i++) begin
                            if (runlen_reg == 16'(i)) prefix_next[8*i +: 8] = char_byte;
                        end
                        if (runlen_reg != 16'hFFFF) runlen_next = runlen_reg + 16'd1;
                        consumed = 1'b1;
                    end
                end
                default: ;
            endcase

            if (!consumed) begin
                fl = flush_tok(mode_reg, start_reg, runlen_reg, prefix_reg, line_reg);
                if (fl.valid) begin
                    toks[cnt] = fl.tok;
                    cnt       = cnt + 2'd1;
                end
                mode_next = M_IDLE;
                if (is_punct) begin
                    toks[cnt].kind  = punct_kind;
                    toks[cnt].start = 16'(pos_reg);
                    toks[cnt].len   = 16'd1;
                    toks[cnt].line  = line_reg;
                    cnt = cnt + 2'd1;
                end else if (char_byte == CH_EQ || char_byte == CH_LT || char_byte == CH_GT ||
                             is_digit) begin
                    mode_next   = (char_byte == CH_EQ) ? M_EQ :
                                  (char_byte == CH_LT) ? M_LT :
                                  (char_byte == CH_GT) ? M_GT : M_NUM;
                    start_next  = pos_reg;
                    runlen_next = 16'd1;
                    prefix_next = '0;
                end else if (is_alpha) begin
                    mode_next   = M_ID;
                    start_next  = pos_reg;
                    runlen_next = 16'd1;
                    prefix_next = PF_W'(char_byte);
                end else if (char_byte == CH_NL) begin
                    if (line_reg != 16'hFFFF) line_next = line_reg + 16'd1;
                end
            end

            if (pos_reg < POS_W'(POS_CAP)) pos_next = pos_reg + 1'b1;
        end

        if (end_of_source) begin
            fl = flush_tok(mode_next, start_next, runlen_next, prefix_next, line_next);
            if (fl.valid) begin
                toks[cnt] = fl.tok;
                cnt       = cnt + 2'd1;
            end
            toks[cnt].kind  = K_EOF;
            toks[cnt].start = 16'(pos_next);
            toks[cnt].len   = 16'd0;
            toks[cnt].line  = line_next;
            cnt = cnt + 2'd1;

            mode_next   = M_IDLE;
            start_next  = '0;
            pos_next    = '0;
            line_next   = 16'd1;
            prefix_next = '0;
            runlen_next = 16'd0;
        end
    end

    assign push             = accept && (cnt != 2'd0);
    assign push_entry.count = cnt;
    assign push_entry.tok   = toks;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg   <= M_IDLE;
            start_reg  <= '0;
            pos_reg    <= '0;
            line_reg   <= 16'd1;
            prefix_reg <= '0;
            runlen_reg <= 16'd0;
        end else if (accept) begin
            mode_reg   <= mode_next;
            start_reg  <= start_next;
            pos_reg    <= pos_next;
            line_reg   <= line_next;
            prefix_reg <= prefix_next;
            runlen_reg <= runlen_next;
        end
    end

endmodule

/* rtl/sct_queue.sv */
// Small queue of token groups between the front scanner and the output stage.
// Depends on sct_pkg.
module sct_queue
    import sct_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  entry_t    push_entry,
    input  logic      pop,
    output entry_t    head,
    output q_status_t q_stat
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    entry_t         store [QUEUE_DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [AW:0]    fill_reg, fill_next;

    assign q_stat.empty = (fill_reg == '0);
    assign q_stat.full  = (fill_reg == (AW+1)'(QUEUE_DEPTH));
    assign head         = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push) store[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

/* rtl/sct_back.sv */
// Output stage: walks the tokens of the head queue entry and presents them one per transaction.
// Depends on sct_pkg; reads from sct_queue.
module sct_back
    import sct_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  entry_t    head,
    input  q_status_t q_stat,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_ready,
    output tok_t      out_tok,
    output logic      out_last
);

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    tok_t       tok_reg, tok_next;
    logic       last_reg, last_next;
    logic       load;
    logic       head_last;

    assign load      = !valid_reg || out_ready;
    assign head_last = (idx_reg == head.count - 2'd1);
    assign pop       = load && !q_stat.empty && head_last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        tok_next   = tok_reg;
        last_next  = last_reg;
        if (load) begin
            valid_next = !q_stat.empty;
            if (!q_stat.empty) begin
                tok_next  = head.tok[idx_reg];
                last_next = head_last;
                idx_next  = head_last ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg  <= tok_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_tok   = tok_reg;
    assign out_last  = last_reg;

endmodule

/* rtl/source_char_tokenizer.sv */
// Source character tokenizer: a byte stream in, a token stream out.
// One source byte is accepted per cycle while the four-entry token queue has room; the
// scanner puts every token of a byte into one queue entry. The output side sends one
// token per cycle while m_tready is held high, so a byte that yields two or three
// tokens (a finished run, a punctuation mark, the EOF token) holds the output port for
// each of its tokens in turn, and the output port's one token per cycle sets the
// sustained rate. A token passes through its queue entry and then the output register
// before it appears at the output. Depends on sct_pkg, sct_front, sct_queue and sct_back.
module source_char_tokenizer
    import sct_pkg::*;
#(
    parameter int MAX_SOURCE_BYTES = 65536,
    parameter int KEYWORD_CHARS    = 5
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_byte
    input  logic        s_tuser,   // has_char
    input  logic        s_tlast,   // end_of_source
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // start_offset, token_length, line_number
    output logic [4:0]  m_tuser,   // token_kind
    output logic        m_tlast    // last_in_run
);

    localparam int POS_CAP = (MAX_SOURCE_BYTES - 1 > 65535) ? 65535 : MAX_SOURCE_BYTES - 1;
    localparam int POS_W   = $clog2(POS_CAP + 1);

    q_status_t q_stat;
    logic      push;
    entry_t    push_entry;
    logic      pop;
    entry_t    head;
    tok_t      out_tok;

    sct_front #(
        .POS_W    (POS_W),
        .POS_CAP  (POS_CAP),
        .KW_CHARS (KEYWORD_CHARS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .char_byte     (s_tdata),
        .has_char      (s_tuser),
        .end_of_source (s_tlast),
        .q_stat        (q_stat),
        .push          (push),
        .push_entry    (push_entry)
    );

    sct_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_stat     (q_stat)
    );

    sct_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_stat    (q_stat),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_tok   (out_tok),
        .out_last  (m_tlast)
    );

    assign m_tdata = {out_tok.line, out_tok.len, out_tok.start};
    assign m_tuser = out_tok.kind;

`ifndef SYNTHESIS
    // The EOF token always closes the tokens of its byte and carries no characters.
    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == K_EOF |-> m_tlast && m_tdata[31:16] == 16'd0)
        else $error("EOF token without last flag or with nonzero length");

    // No token kind beyond EOF is ever produced.
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser <= K_EOF)
        else $error("token kind out of range");

    // Every transaction pushed into the queue carries at least one token and never
    // lands on a full queue.
    a_push_ok: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> push_entry.count != 2'd0 && !q_stat.full)
        else $error("bad queue push");
`endif

endmodule
